>>> rtl/pct_pkg.sv
package pct_pkg;

  localparam logic [7:0] PCT_SIGN = 8'h25;
  localparam logic [7:0] CHR_PLUS = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // one queue entry: the one or two results caused by one input item
  typedef struct packed {
    logic       two;
    logic [7:0] r0_byte;
    logic       r0_nodata;
    logic [7:0] r1_byte;
    logic       last;
  } pct_entry_t;

endpackage

>>> rtl/pct_front.sv
module pct_front
  import pct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       ent_valid,
  output pct_entry_t ent
);

  // hex digit value, valid flag on top
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // base-16 parse of up to two gathered bytes, truncated to 8 bits
  function automatic logic [7:0] hex_decode(input logic [7:0] d0, input logic [7:0] d1,
                                            input logic [1:0] cnt);
    logic [7:0] d [2];
    logic [7:0] acc;
    logic [4:0] hv;
    logic       neg;
    logic       skipping;
    logic       stop;
    d[0] = d0;
    d[1] = d1;
    acc = 8'd0;
    neg = 1'b0;
    skipping = 1'b1;
    stop = 1'b0;
    for (int k = 0; k < 2; k++) begin
      hv = hex_value(d[k]);
      if (2'(k) < cnt && !stop) begin
        if (skipping && is_blank(d[k])) begin
          skipping = 1'b1;
        end else if (skipping && (d[k] == CHR_PLUS || d[k] == CHR_MINUS)) begin
          neg = (d[k] == CHR_MINUS);
          skipping = 1'b0;
        end else begin
          skipping = 1'b0;
          if (hv[4]) acc = {acc[3:0], hv[3:0]};
          else stop = 1'b1;
        end
      end
    end
    if (neg) acc = 8'd0 - acc;
    return acc;
  endfunction

  logic       escape_open, escape_open_next;
  logic [1:0] digit_count, digit_count_next;
  logic [7:0] digit_store [2];
  logic [7:0] store_next [2];
  logic       field_start, field_start_next;

  // classify the item and build its results
  always_comb begin
    logic [1:0] n;
    logic [7:0] r0, r1;
    logic       nd0;
    n = 2'd0;
    r0 = 8'd0;
    r1 = 8'd0;
    nd0 = 1'b0;
    escape_open_next = escape_open;
    digit_count_next = digit_count;
    store_next[0] = digit_store[0];
    store_next[1] = digit_store[1];
    field_start_next = field_start;

    if (field_start && in_last) begin
      n = 2'd1;
      r0 = in_byte;
    end else begin
      field_start_next = 1'b0;
      if (!escape_open) begin
        if (in_byte == PCT_SIGN) escape_open_next = 1'b1;
        else begin
          n = 2'd1;
          r0 = in_byte;
        end
      end else if (digit_count == 2'd0 && in_byte == PCT_SIGN) begin
        escape_open_next = 1'b0;
        n = 2'd1;
        r0 = PCT_SIGN;
      end else if (digit_count < 2'd2) begin
        store_next[digit_count[0]] = in_byte;
        digit_count_next = digit_count + 2'd1;
      end else begin
        n = 2'd1;
        r0 = hex_decode(digit_store[0], digit_store[1], digit_count);
        digit_count_next = 2'd0;
        escape_open_next = (in_byte == PCT_SIGN);
        if (in_byte != PCT_SIGN) begin
          n = 2'd2;
          r1 = in_byte;
        end
      end
      // field end: flush pending digits, or close with an empty result
      if (in_last) begin
        if (digit_count_next != 2'd0) begin
          if (n == 2'd0) begin
            r0 = hex_decode(store_next[0], store_next[1], digit_count_next);
            n = 2'd1;
          end else begin
            r1 = hex_decode(store_next[0], store_next[1], digit_count_next);
            n = 2'd2;
          end
        end
        if (n == 2'd0) begin
          n = 2'd1;
          r0 = 8'd0;
          nd0 = 1'b1;
        end
      end
    end

    if (in_last) begin
      escape_open_next = 1'b0;
      digit_count_next = 2'd0;
      field_start_next = 1'b1;
    end

    ent_valid = take && (n != 2'd0);
    ent.two = (n == 2'd2);
    ent.r0_byte = r0;
    ent.r0_nodata = nd0;
    ent.r1_byte = r1;
    ent.last = in_last;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_open <= 1'b0;
      digit_count <= 2'd0;
      field_start <= 1'b1;
    end else if (take) begin
      escape_open <= escape_open_next;
      digit_count <= digit_count_next;
      field_start <= field_start_next;
    end
  end

  // gathered digits, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      digit_store[0] <= store_next[0];
      digit_store[1] <= store_next[1];
    end
  end

endmodule

>>> rtl/pct_queue.sv
module pct_queue
  import pct_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  pct_entry_t wr_data,
  input  logic       rd_en,
  output pct_entry_t rd_data,
  output logic       q_full,
  output logic       q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  pct_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

>>> rtl/pct_back.sv
module pct_back
  import pct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  pct_entry_t head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       no_data,
  output logic       out_last
);

  // which result of the head entry is shown
  logic second;
  logic take;

  assign empty = q_empty;
  assign take  = pop && !q_empty;
  assign q_pop = take && (second || !head.two);

  // result select
  always_comb begin
    if (second) begin
      out_byte = head.r1_byte;
      no_data  = 1'b0;
    end else begin
      out_byte = head.r0_byte;
      no_data  = head.r0_nodata;
    end
    out_last = head.last && (second || !head.two);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= head.two && !second;
    end
  end

endmodule

>>> rtl/percent_decoder_top.sv
// percent-encoded field decoder
//
// input channel: in_byte/in_last are taken at a clock edge with push high and
// full low; in_last marks the final byte of a field. result channel: while
// empty is low the oldest result sits on out_byte/no_data/out_last and is
// taken at a clock edge with pop high. no_data marks the empty closing result
// of a field that decoded to nothing; out_last marks a field's final result.
// the front stage classifies each item in the cycle it is taken and writes
// its one or two results as a single entry into a QDEPTH-entry queue; an
// item that produces no result writes nothing. a result is visible once its
// entry is registered in the queue and all entries ahead of it are popped.
// the front takes one item per cycle while the queue has room; the back
// stage gives one result per cycle while pop is high, so an item with two
// results holds its queue entry until both of its results are taken.
// when pop is held low the queue fills, then full rises and input stalls.
// reset clears the queue and all escape state; the next byte opens a field.
module percent_decoder_top
  import pct_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       no_data,
  output logic       out_last
);

  pct_entry_t ent, head;
  logic       ent_valid, q_empty, q_pop, take;

  assign take = push && !full;

  pct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .ent_valid (ent_valid),
    .ent       (ent)
  );

  pct_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ent_valid),
    .wr_data (ent),
    .rd_en   (q_pop),
    .rd_data (head),
    .q_full  (full),
    .q_empty (q_empty)
  );

  pct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .no_data  (no_data),
    .out_last (out_last)
  );

endmodule
